/* rtl/matrix_inverse_3x3_core_defines.svh */
// Assertion macros shared by the matrix inverse core.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`define MATRIX_INVERSE_3X3_CORE_DEFINES_SVH

// Check that a condition implies a consequence, sampled on clk.
`define MI3_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mi3 check failed");

// Check that a condition never holds, sampled on clk.
`define MI3_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mi3 forbidden condition");

`endif

/* rtl/mi3_pkg.sv */
// Types and constants of the 3x3 matrix inverse core.
// Used by every module of the core; depends on nothing.
`default_nettype none
package mi3_pkg;

  localparam int NUM_EL        = 9;
  localparam int ELEM_W        = 32;
  localparam int THR_W         = 31;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 64;
  localparam int COF_MAG_W     = 64;
  localparam int DET_MAG_W     = 96;
  localparam int Q_W           = 32;
  localparam int QDEPTH        = 2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] inv00;
    logic signed [ELEM_W-1:0] inv01;
    logic signed [ELEM_W-1:0] inv02;
    logic signed [ELEM_W-1:0] inv10;
    logic signed [ELEM_W-1:0] inv11;
    logic signed [ELEM_W-1:0] inv12;
    logic signed [ELEM_W-1:0] inv20;
    logic signed [ELEM_W-1:0] inv21;
    logic signed [ELEM_W-1:0] inv22;
    logic                     singular;
  } out_item_t;

  // Element signs and magnitudes, as queued between front and back.
  typedef struct packed {
    logic [NUM_EL-1:0]             neg;
    logic [NUM_EL-1:0][ELEM_W-1:0] mag;
  } elem_word_t;

  // Cofactors and determinant handed to the divider.
  typedef struct packed {
    logic                             singular;
    logic                             detn;
    logic [DET_MAG_W-1:0]             detm;
    logic [NUM_EL-1:0]                cofn;
    logic [NUM_EL-1:0][COF_MAG_W-1:0] cofm;
  } det_word_t;

  // Element indexes {p,q,r,s}: adjugate entry = x[p]*x[q] - x[r]*x[s].
  function automatic logic [15:0] adj_sel(input logic [3:0] i);
    logic [15:0] r;
    case (i)
      4'd0:    r = {4'd4, 4'd8, 4'd5, 4'd7};
      4'd1:    r = {4'd2, 4'd7, 4'd1, 4'd8};
      4'd2:    r = {4'd1, 4'd5, 4'd2, 4'd4};
      4'd3:    r = {4'd5, 4'd6, 4'd3, 4'd8};
      4'd4:    r = {4'd0, 4'd8, 4'd2, 4'd6};
      4'd5:    r = {4'd2, 4'd3, 4'd0, 4'd5};
      4'd6:    r = {4'd3, 4'd7, 4'd4, 4'd6};
      4'd7:    r = {4'd1, 4'd6, 4'd0, 4'd7};
      4'd8:    r = {4'd0, 4'd4, 4'd1, 4'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/mi3_front.sv */
// Front end: takes a matrix word and splits each element into sign and magnitude.
// Depends on mi3_pkg.
`default_nettype none
module mi3_front (
  input  wire logic                 start,
  input  wire mi3_pkg::in_item_t    in_data,
  input  wire logic                 q_full,
  output logic                      busy,
  output logic                      push,
  output mi3_pkg::elem_word_t       push_word
);

  logic [mi3_pkg::NUM_EL-1:0][mi3_pkg::ELEM_W-1:0] el;

  // Gather the elements row-major
  assign el = {in_data.m22, in_data.m21, in_data.m20,
               in_data.m12, in_data.m11, in_data.m10,
               in_data.m02, in_data.m01, in_data.m00};

  // Hold off the source only when the queue is full
  assign busy = q_full;
  assign push = start && !q_full;

  // Split into sign and magnitude
  always_comb begin
    for (int i = 0; i < mi3_pkg::NUM_EL; i++) begin
      push_word.neg[i] = el[i][mi3_pkg::ELEM_W-1];
      push_word.mag[i] = el[i][mi3_pkg::ELEM_W-1] ? (~el[i] + 1'b1) : el[i];
    end
  end

endmodule
`default_nettype wire

/* rtl/mi3_queue.sv */
// Two-entry queue between front and back; the back drains one word a cycle.
// Depends on mi3_pkg.
`default_nettype none
module mi3_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mi3_pkg::elem_word_t push_word,
  output logic                     full,
  output logic                     pop_valid,
  output mi3_pkg::elem_word_t      pop_word
);

  localparam int PW = $clog2(mi3_pkg::QDEPTH);

  mi3_pkg::elem_word_t mem [mi3_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop_valid_r;
  logic          pop;

  assign pop       = (count_r != '0);
  assign full      = (count_r == (PW+1)'(mi3_pkg::QDEPTH));
  assign pop_valid = pop_valid_r;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      pop_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      pop_valid_r <= pop;
    end
  end

  // Write a word into storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

  // Read the head word into the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      pop_word <= mem[rd_ptr_r];
    end
  end

endmodule
`default_nettype wire

/* rtl/mi3_det.sv */
// Back end, first half: element products, cofactors, determinant, singular test.
// Depends on mi3_pkg.
`default_nettype none
module mi3_det #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire mi3_pkg::elem_word_t           in_word,
  input  wire logic [mi3_pkg::THR_W-1:0]     threshold,
  output logic                               out_vld,
  output mi3_pkg::det_word_t                 out_word
);

  localparam int N  = mi3_pkg::NUM_EL;
  localparam int PW = mi3_pkg::PROD_W;
  localparam int CW = PW + 2;
  localparam int CM = mi3_pkg::COF_MAG_W;
  localparam int DM = mi3_pkg::DET_MAG_W;
  localparam int DW = DM + 2;
  localparam int EW = mi3_pkg::ELEM_W;

  logic va_r, vb_r, vc_r, vd_r, ve_r;

  // stage A
  logic [PW-1:0] pa_r [N];
  logic [PW-1:0] qa_r [N];
  logic [N-1:0]  pn_r, qn_r;
  logic [2:0]    ena_r;
  logic [EW-1:0] ema_r [3];
  // stage B
  logic signed [CW-1:0] cof_r [N];
  logic [2:0]    enb_r;
  logic [EW-1:0] emb_r [3];
  // stage C
  logic [CM-1:0] cofmc_r [N];
  logic [N-1:0]  cofnc_r;
  logic [PW-1:0] lo_r [3];
  logic [PW-1:0] hi_r [3];
  logic [2:0]    tn_r;
  // stage D
  logic [CM-1:0] cofmd_r [N];
  logic [N-1:0]  cofnd_r;
  logic signed [DW-1:0] det_r;

  logic signed [DW-1:0] st [3];
  logic signed [DW-1:0] det_neg;
  logic [DM-1:0]        detm;

  // Valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  // Stage A: the eighteen element products
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      logic [15:0] s;
      s = mi3_pkg::adj_sel(4'(i));
      pa_r[i] <= PW'(in_word.mag[s[15:12]]) * PW'(in_word.mag[s[11:8]]);
      pn_r[i] <= in_word.neg[s[15:12]] ^ in_word.neg[s[11:8]];
      qa_r[i] <= PW'(in_word.mag[s[7:4]]) * PW'(in_word.mag[s[3:0]]);
      qn_r[i] <= in_word.neg[s[7:4]] ^ in_word.neg[s[3:0]];
    end
    for (int k = 0; k < 3; k++) begin
      ena_r[k] <= in_word.neg[k];
      ema_r[k] <= in_word.mag[k];
    end
  end

  // Stage B: signed cofactors
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      logic signed [CW-1:0] sp, sq;
      sp = $signed({2'b00, pa_r[i]});
      sq = $signed({2'b00, qa_r[i]});
      cof_r[i] <= (pn_r[i] ? -sp : sp) - (qn_r[i] ? -sq : sq);
    end
    enb_r <= ena_r;
    for (int k = 0; k < 3; k++) begin
      emb_r[k] <= ema_r[k];
    end
  end

  // Stage C: cofactor magnitudes, split first-row products
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      logic signed [CW-1:0] a;
      a = cof_r[i][CW-1] ? -cof_r[i] : cof_r[i];
      cofmc_r[i] <= a[CM-1:0];
      cofnc_r[i] <= cof_r[i][CW-1];
    end
    for (int k = 0; k < 3; k++) begin
      logic signed [CW-1:0] a;
      a = cof_r[3*k][CW-1] ? -cof_r[3*k] : cof_r[3*k];
      lo_r[k] <= PW'(a[31:0]) * PW'(emb_r[k]);
      hi_r[k] <= PW'(a[63:32]) * PW'(emb_r[k]);
      tn_r[k] <= cof_r[3*k][CW-1] ^ enb_r[k];
    end
  end

  // Stage D: sum the three signed terms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [DM-1:0] t;
      t = {hi_r[k], 32'd0} + DM'(lo_r[k]);
      st[k] = tn_r[k] ? -$signed({2'b00, t}) : $signed({2'b00, t});
    end
  end

  always_ff @(posedge clk) begin
    det_r <= st[0] + st[1] + st[2];
    for (int i = 0; i < N; i++) begin
      cofmd_r[i] <= cofmc_r[i];
    end
    cofnd_r <= cofnc_r;
  end

  // Stage E: magnitude and singular test
  assign det_neg = -det_r;
  assign detm    = det_r[DW-1] ? det_neg[DM-1:0] : det_r[DM-1:0];

  always_ff @(posedge clk) begin
    out_word.singular <= (detm >> (2*FRAC_BITS)) <= DM'(threshold);
    out_word.detn     <= det_r[DW-1];
    out_word.detm     <= detm;
    out_word.cofn     <= cofnd_r;
    for (int i = 0; i < N; i++) begin
      out_word.cofm[i] <= cofmd_r[i];
    end
  end

  assign out_vld = ve_r;

endmodule
`default_nettype wire

/* rtl/mi3_div.sv */
// Back end, second half: nine-lane pipelined restoring divider and saturation.
// Depends on mi3_pkg.
`default_nettype none
module mi3_div #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  input  wire mi3_pkg::det_word_t  in_word,
  output logic                     out_strobe,
  output mi3_pkg::out_item_t       out_data
);

  localparam int N  = mi3_pkg::NUM_EL;
  localparam int QW = mi3_pkg::Q_W;
  localparam int DM = mi3_pkg::DET_MAG_W;
  localparam int RW = DM + QW;
  localparam int NS = QW;

  logic [RW-1:0] rem_r [NS+1][N];
  logic [QW-1:0] q_r   [NS+1][N];
  logic [N-1:0]  neg_r [NS+1];
  logic [DM-1:0] d_r   [NS+1];
  logic          sing_r[NS+1];
  logic          v_r   [NS+1];

  logic [QW-1:0]      res [N];
  logic               strobe_r;
  mi3_pkg::out_item_t out_r, out_nxt;

  // Setup: scale numerator, catch quotients that cannot fit
  always_ff @(posedge clk) begin
    for (int l = 0; l < N; l++) begin
      logic [RW-1:0] num;
      logic          ovf;
      num = RW'(in_word.cofm[l]) << (2*FRAC_BITS);
      ovf = num >= (RW'(in_word.detm) << QW);
      rem_r[0][l] <= ovf ? '0 : num;
      q_r[0][l]   <= ovf ? '1 : '0;
      neg_r[0][l] <= in_word.cofn[l] ^ in_word.detn;
    end
    d_r[0]    <= in_word.detm;
    sing_r[0] <= in_word.singular;
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int J = NS - 1 - s;
    always_ff @(posedge clk) begin
      for (int l = 0; l < N; l++) begin
        logic [RW-1:0] dsh;
        dsh = RW'(d_r[s]) << J;
        if (rem_r[s][l] >= dsh) begin
          rem_r[s+1][l] <= rem_r[s][l] - dsh;
          q_r[s+1][l]   <= q_r[s][l] | (QW'(1) << J);
        end else begin
          rem_r[s+1][l] <= rem_r[s][l];
          q_r[s+1][l]   <= q_r[s][l];
        end
      end
      neg_r[s+1]  <= neg_r[s];
      d_r[s+1]    <= d_r[s];
      sing_r[s+1] <= sing_r[s];
    end
  end

  // Valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) begin
        v_r[s] <= 1'b0;
      end
      strobe_r <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
      for (int s = 0; s < NS; s++) begin
        v_r[s+1] <= v_r[s];
      end
      strobe_r <= v_r[NS];
    end
  end

  // Apply sign, saturate, drop to zero when singular
  always_comb begin
    for (int l = 0; l < N; l++) begin
      logic [QW-1:0] q;
      q = q_r[NS][l];
      if (sing_r[NS]) begin
        res[l] = '0;
      end else if (neg_r[NS][l]) begin
        res[l] = ~((q > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}} : q) + 1'b1;
      end else begin
        res[l] = (q > {1'b0, {(QW-1){1'b1}}}) ? {1'b0, {(QW-1){1'b1}}} : q;
      end
    end
    out_nxt.inv00    = res[0];
    out_nxt.inv01    = res[1];
    out_nxt.inv02    = res[2];
    out_nxt.inv10    = res[3];
    out_nxt.inv11    = res[4];
    out_nxt.inv12    = res[5];
    out_nxt.inv20    = res[6];
    out_nxt.inv21    = res[7];
    out_nxt.inv22    = res[8];
    out_nxt.singular = sing_r[NS];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule
`default_nettype wire

/* rtl/matrix_inverse_3x3_core.sv */
// Top level of the 3x3 matrix inverse core: front, queue, determinant, divider.
// Depends on mi3_pkg, mi3_front, mi3_queue, mi3_det, mi3_div and the defines header.
//
//   channel  | handshake              | word
//   ---------+------------------------+--------------------------------
//   input    | start / busy           | in_data  (nine Q16.16 elements)
//   result   | out_strobe (no stall)  | out_data (inverse, singular)
//   config   | cfg_valid / cfg_ready  | cfg_data (singular threshold)
//
// One matrix is taken every cycle; out_strobe rises once the result has passed
// the queue, the determinant stages and the divider's 32 quotient-bit stages.
// rst_n is synchronous; it clears valids, queue pointers and the threshold.
// The result side never stalls, so busy stays low in operation.
`default_nettype none
`include "matrix_inverse_3x3_core_defines.svh"
module matrix_inverse_3x3_core #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire mi3_pkg::in_item_t           in_data,
  output logic                             out_strobe,
  output mi3_pkg::out_item_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mi3_pkg::THR_W-1:0]   cfg_data
);

  logic                       q_full, push, q_vld, d_vld;
  mi3_pkg::elem_word_t        push_word, q_word;
  mi3_pkg::det_word_t         d_word;
  logic [mi3_pkg::THR_W-1:0]  thr_r;

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  mi3_front u_front (
    .start     (start),
    .in_data   (in_data),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_word (push_word)
  );

  mi3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop_valid (q_vld),
    .pop_word  (q_word)
  );

  mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (q_vld),
    .in_word   (q_word),
    .threshold (thr_r),
    .out_vld   (d_vld),
    .out_word  (d_word)
  );

  mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (d_vld),
    .in_word    (d_word),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  `MI3_CHECK(a_sing_zero, out_strobe && out_data.singular, out_data.inv00 == '0 && out_data.inv11 == '0 && out_data.inv22 == '0)
  `MI3_NEVER(a_no_backpressure, busy)
  `MI3_CHECK(a_queue_drains, start && !busy, ##2 q_vld)

endmodule
`default_nettype wire

/* tb/sv/mi3_checker.sv */
// Checker for the 3x3 matrix inverse core: predicts each inverse and compares.
// Depends on mi3_pkg for the word types; watches the start, result and cfg channels.
`default_nettype none
module mi3_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire mi3_pkg::in_item_t         in_data,
  input  wire logic                      out_strobe,
  input  wire mi3_pkg::out_item_t        out_data,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [mi3_pkg::THR_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             inverse_count,
  output int                             singular_count
);
  import mi3_pkg::*;

  localparam int SHIFT = 2 * FRAC_BITS_DEF;

  logic [THR_W-1:0] thr_copy;
  out_item_t        inverse_queue[$];

  // Exact inverse by cofactors, then saturating division by the determinant, or all zero when singular.
  function automatic out_item_t predict_inverse(in_item_t m, logic [THR_W-1:0] thr);
    logic signed [127:0] e[9];
    logic signed [127:0] cof[9];
    logic signed [127:0] det;
    logic [127:0]        dmag, cmag, quo, lim;
    logic [31:0]         v[9];
    logic                sing;
    int                  pq[9][4];
    logic [287:0]        flat;
    pq = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
           '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
           '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
    flat = m;
    for (int i = 0; i < 9; i++) e[i] = $signed(flat[287-32*i -: 32]);
    for (int i = 0; i < 9; i++)
      cof[i] = e[pq[i][0]] * e[pq[i][1]] - e[pq[i][2]] * e[pq[i][3]];
    det  = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    dmag = det[127] ? -det : det;
    lim  = ({97'd0, thr} + 128'd1) << SHIFT;
    sing = dmag < lim;
    for (int i = 0; i < 9; i++) begin
      if (sing) begin
        v[i] = '0;
      end else begin
        cmag = cof[i][127] ? -cof[i] : cof[i];
        quo  = (cmag << SHIFT) / dmag;
        if (cof[i][127] != det[127]) begin
          v[i] = (quo > 128'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
        end else begin
          v[i] = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end
      end
    end
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], sing};
  endfunction

  // Track threshold, queue expectations, compare results.
  always @(posedge clk) begin
    out_item_t    want;
    logic [288:0] w, a;
    if (!rst_n) begin
      thr_copy <= '0;
      inverse_queue.delete();
      fail_count     <= 0;
      inverse_count  <= 0;
      singular_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) thr_copy <= cfg_data;
      if (start && !busy) inverse_queue.push_back(predict_inverse(in_data, thr_copy));
      if (out_strobe) begin
        if (inverse_queue.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = inverse_queue.pop_front();
          w = want;
          a = out_data;
          inverse_count <= inverse_count + 1;
          if (a[0]) singular_count <= singular_count + 1;
          if (w != a) fail_count <= fail_count + 1;
          for (int i = 0; i < 9; i++)
            if (w[288-32*i -: 32] != a[288-32*i -: 32])
              $display("%0t: inv%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                       w[288-32*i -: 32], a[288-32*i -: 32]);
          if (w[0] != a[0])
            $display("%0t: singular expected %b actual %b", $time, w[0], a[0]);
        end
      end
    end
  end

  assign pending_count = inverse_queue.size();

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Top of the matrix inverse testbench: clock, reset, stimulus and verdict.
// Depends on mi3_pkg, matrix_inverse_3x3_core and mi3_checker.
`default_nettype none
module tb;
  import mi3_pkg::*;

  localparam int MAX_CYCLES = 300000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  in_item_t         in_data = '0;
  logic             cfg_valid = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;
  logic             busy, out_strobe, cfg_ready;
  out_item_t        out_data;
  int               fail_count, pending_count, inverse_count, singular_count;
  int               cycle_count = 0;
  int               send_idle_pct = 0;

  matrix_inverse_3x3_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  mi3_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .inverse_count(inverse_count), .singular_count(singular_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("matrix_inverse_3x3_core: mismatch");
      $finish;
    end
  end

  // Idle cycle by cycle at the set rate, then present one matrix word and hold until taken.
  task automatic send_matrix(input in_item_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= m;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Drain results, let the pipeline settle, then write the threshold.
  task automatic write_threshold(input logic [THR_W-1:0] thr);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return $urandom_range(8) - 4;
      default: return $urandom_range(8 * ONE) - 4 * ONE;
    endcase
  endfunction

  function automatic in_item_t rnd_matrix();
    logic [31:0] x[9];
    int          kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) x[i] = (kind < 2) ? $urandom() : rnd_elem();
    if (kind == 2) begin
      // duplicate a row so the matrix is singular
      x[6] = x[0]; x[7] = x[1]; x[8] = x[2];
    end else if (kind == 3) begin
      // near identity, modest perturbation
      for (int i = 0; i < 9; i++)
        x[i] = ((i % 4 == 0) ? ONE : 32'd0) + $urandom_range(ONE / 2) - ONE / 4;
    end
    return {x[0], x[1], x[2], x[3], x[4], x[5], x[6], x[7], x[8]};
  endfunction

  function automatic in_item_t diag(input logic [31:0] a, b, c);
    return {a, 32'd0, 32'd0, 32'd0, b, 32'd0, 32'd0, 32'd0, c};
  endfunction

  initial begin
    logic [THR_W-1:0] thr_list[5];
    int               idle_list[5];
    thr_list  = '{31'd0, 31'd1, 31'h0001_0000, $urandom() >> 1, 31'h7FFF_FFFF};
    idle_list = '{32, 32, 86, 0, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed matrices: identity, zero, extremes, saturation, rank deficient.
    write_threshold(31'd0);
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix('0);
    send_matrix(diag(-ONE, -ONE, -ONE));
    send_matrix(diag(2 * ONE, ONE / 2, -4 * ONE));
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'hFFFF_FFFF}});
    send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_matrix(diag(32'd1, 32'd1, 32'd1));
    send_matrix(diag(32'd256, 32'd256, 32'd256));
    send_matrix(diag(32'd1 << 11, 32'd1 << 11, 32'd1 << 10));
    send_matrix(diag(ONE, ONE, 32'h7FFF_FFFF));
    send_matrix(diag(ONE, -ONE, 32'h8000_0000));
    send_matrix({ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE,
                 9 * ONE});
    send_matrix({ONE, 2 * ONE, 3 * ONE, 32'd0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 32'd0});
    send_matrix({32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'd0, 32'd0, 32'd0, 32'h8000_0000});
    send_matrix({32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0});

    // Random phases under several thresholds and idling patterns.
    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_list[p]);
      send_idle_pct = idle_list[p];
      repeat (330) send_matrix(rnd_matrix());
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Checked %0d inverses (%0d singular) over five threshold settings,",
             inverse_count, singular_count);
    $display("with sender gaps at 32 and 86 percent and back-to-back streams.");
    if (fail_count == 0) begin
      $display("matrix_inverse_3x3_core: match");
    end else begin
      $display("matrix_inverse_3x3_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_queue.sv
rtl/mi3_det.sv
rtl/mi3_div.sv
rtl/matrix_inverse_3x3_core.sv
tb/sv/mi3_checker.sv
tb/sv/tb.sv
